// ===== rtl/core/text_console_char_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Text console character engine assertion macros
// Shared concurrent assertion forms for the engine's modules.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCCE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tcce assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TCCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tcce assertion failed");

`endif

// ===== rtl/core/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console character engine package
// Widths, codes, control store contents and the dispatch decoder.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int COL_W = 7;
    localparam int ROW_W = 6;
    localparam int NUM_W = 16;

    localparam logic [7:0] MAX_COLUMNS = 8'd128;
    localparam logic [6:0] MAX_LINES   = 7'd64;
    localparam logic [7:0] TAB_WIDTH   = 8'd8;

    localparam logic [7:0] RESET_COLUMNS = 8'd80;
    localparam logic [6:0] RESET_ROWS    = 7'd30;

    localparam logic CFG_SCREEN_COLUMNS = 1'b0;
    localparam logic CFG_SCREEN_ROWS    = 1'b1;

    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_SCROLL = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_ERASE  = 3'd3;
    localparam logic [2:0] OP_CURSOR = 3'd4;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_CSI  = 2'd2;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_FIRST = 8'h20;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_J     = 8'h4a;
    localparam logic [7:0] CH_K     = 8'h4b;
    localparam logic [7:0] CH_LBR   = 8'h5b;

    localparam logic [NUM_W-1:0] NUM_MAX = 16'hffff;
    localparam logic [NUM_W-1:0] NUM_CLEAR_ALL = 16'd2;

    // Emit selects.
    localparam logic [2:0] EM_NONE        = 3'd0;
    localparam logic [2:0] EM_WRITE_BYTE  = 3'd1;
    localparam logic [2:0] EM_WRITE_SPACE = 3'd2;
    localparam logic [2:0] EM_ERASE       = 3'd3;
    localparam logic [2:0] EM_SCROLL      = 3'd4;
    localparam logic [2:0] EM_CLEAR       = 3'd5;
    localparam logic [2:0] EM_CURSOR      = 3'd6;
    localparam logic [2:0] EM_SCR_OR_CUR  = 3'd7;

    // Last-of-run selects.
    localparam logic [1:0] LS_YES   = 2'd0;
    localparam logic [1:0] LS_NOSCR = 2'd1;
    localparam logic [1:0] LS_TAB   = 2'd2;

    // Cursor operations.
    localparam logic [2:0] CUR_KEEP = 3'd0;
    localparam logic [2:0] CUR_HOME = 3'd1;
    localparam logic [2:0] CUR_CR   = 3'd2;
    localparam logic [2:0] CUR_BS   = 3'd3;
    localparam logic [2:0] CUR_ADV  = 3'd4;
    localparam logic [2:0] CUR_TAB  = 3'd5;
    localparam logic [2:0] CUR_LF   = 3'd6;

    // Escape parser operations.
    localparam logic [2:0] ES_KEEP  = 3'd0;
    localparam logic [2:0] ES_IDLE  = 3'd1;
    localparam logic [2:0] ES_ESC   = 3'd2;
    localparam logic [2:0] ES_CSI   = 3'd3;
    localparam logic [2:0] ES_DIGIT = 3'd4;

    // Jump conditions.
    localparam logic [1:0] JC_NEXT = 2'd0;
    localparam logic [1:0] JC_SCR  = 2'd1;
    localparam logic [1:0] JC_MORE = 2'd2;

    // Control store addresses.
    localparam logic [3:0] UA_CTRL      = 4'd0;
    localparam logic [3:0] UA_ESC       = 4'd1;
    localparam logic [3:0] UA_ESC_OTHER = 4'd2;
    localparam logic [3:0] UA_CSI_OPEN  = 4'd3;
    localparam logic [3:0] UA_DIGIT     = 4'd4;
    localparam logic [3:0] UA_CLEAR     = 4'd5;
    localparam logic [3:0] UA_HOME      = 4'd6;
    localparam logic [3:0] UA_ERASE     = 4'd7;
    localparam logic [3:0] UA_CR        = 4'd8;
    localparam logic [3:0] UA_BS        = 4'd9;
    localparam logic [3:0] UA_LF        = 4'd10;
    localparam logic [3:0] UA_PRINT     = 4'd11;
    localparam logic [3:0] UA_TAB       = 4'd12;
    localparam logic [3:0] UA_TLOOP     = 4'd13;
    localparam logic [3:0] UA_TTAIL     = 4'd14;
    localparam logic [3:0] UA_SCROLL    = 4'd15;

    typedef struct packed {
        logic [2:0] emit;
        logic [1:0] last;
        logic [2:0] cur;
        logic [2:0] esc;
        logic       wcinc;
        logic [1:0] jc;
        logic [3:0] target;
        logic       fin;
    } t_uword;

    typedef struct packed {
        t_uword word;
        logic   fire;
    } t_dp_ctl;

    typedef struct packed {
        logic       out_free;
        logic       scr;
        logic       more;
        logic [1:0] phase;
        logic       num_two;
    } t_dp_stat;

    function automatic t_uword mk_word(input logic [2:0] emit, input logic [1:0] last,
                                       input logic [2:0] cur, input logic [2:0] esc,
                                       input logic wcinc, input logic [1:0] jc,
                                       input logic [3:0] target, input logic fin);
        t_uword w;
        w.emit   = emit;
        w.last   = last;
        w.cur    = cur;
        w.esc    = esc;
        w.wcinc  = wcinc;
        w.jc     = jc;
        w.target = target;
        w.fin    = fin;
        return w;
    endfunction

    function automatic t_uword ucode_word(input logic [3:0] addr);
        t_uword w;
        case (addr)
            UA_CTRL:      w = mk_word(EM_CURSOR, LS_YES, CUR_KEEP, ES_KEEP, 1'b0,
                                      JC_NEXT, UA_CTRL, 1'b1);
            UA_ESC:       w = mk_word(EM_CURSOR, LS_YES, CUR_KEEP, ES_ESC, 1'b0,
                                      JC_NEXT, UA_ESC, 1'b1);
            UA_ESC_OTHER: w = mk_word(EM_CURSOR, LS_YES, CUR_KEEP, ES_IDLE, 1'b0,
                                      JC_NEXT, UA_ESC_OTHER, 1'b1);
            UA_CSI_OPEN:  w = mk_word(EM_CURSOR, LS_YES, CUR_KEEP, ES_CSI, 1'b0,
                                      JC_NEXT, UA_CSI_OPEN, 1'b1);
            UA_DIGIT:     w = mk_word(EM_CURSOR, LS_YES, CUR_KEEP, ES_DIGIT, 1'b0,
                                      JC_NEXT, UA_DIGIT, 1'b1);
            UA_CLEAR:     w = mk_word(EM_CLEAR, LS_YES, CUR_KEEP, ES_IDLE, 1'b0,
                                      JC_NEXT, UA_CLEAR, 1'b1);
            UA_HOME:      w = mk_word(EM_CURSOR, LS_YES, CUR_HOME, ES_IDLE, 1'b0,
                                      JC_NEXT, UA_HOME, 1'b1);
            UA_ERASE:     w = mk_word(EM_ERASE, LS_YES, CUR_KEEP, ES_IDLE, 1'b0,
                                      JC_NEXT, UA_ERASE, 1'b1);
            UA_CR:        w = mk_word(EM_CURSOR, LS_YES, CUR_CR, ES_KEEP, 1'b0,
                                      JC_NEXT, UA_CR, 1'b1);
            UA_BS:        w = mk_word(EM_CURSOR, LS_YES, CUR_BS, ES_KEEP, 1'b0,
                                      JC_NEXT, UA_BS, 1'b1);
            UA_LF:        w = mk_word(EM_SCR_OR_CUR, LS_YES, CUR_LF, ES_KEEP, 1'b0,
                                      JC_NEXT, UA_LF, 1'b1);
            UA_PRINT:     w = mk_word(EM_WRITE_BYTE, LS_NOSCR, CUR_ADV, ES_KEEP, 1'b0,
                                      JC_SCR, UA_SCROLL, 1'b1);
            UA_TAB:       w = mk_word(EM_NONE, LS_YES, CUR_TAB, ES_KEEP, 1'b0,
                                      JC_NEXT, UA_TAB, 1'b0);
            UA_TLOOP:     w = mk_word(EM_WRITE_SPACE, LS_TAB, CUR_KEEP, ES_KEEP, 1'b1,
                                      JC_MORE, UA_TLOOP, 1'b0);
            UA_TTAIL:     w = mk_word(EM_NONE, LS_YES, CUR_KEEP, ES_KEEP, 1'b0,
                                      JC_SCR, UA_SCROLL, 1'b1);
            UA_SCROLL:    w = mk_word(EM_SCROLL, LS_YES, CUR_KEEP, ES_KEEP, 1'b0,
                                      JC_NEXT, UA_SCROLL, 1'b1);
            default:      w = mk_word(EM_NONE, LS_YES, CUR_KEEP, ES_KEEP, 1'b0,
                                      JC_NEXT, UA_CTRL, 1'b1);
        endcase
        return w;
    endfunction

    // Selects the routine that handles one byte.
    function automatic logic [3:0] dispatch(input logic [7:0] ch, input logic [1:0] phase,
                                            input logic num_two);
        logic [3:0] a;
        a = UA_CTRL;
        if (phase == PH_ESC) begin
            a = (ch == CH_LBR) ? UA_CSI_OPEN : UA_ESC_OTHER;
        end else if (phase != PH_IDLE) begin
            if (ch inside {[CH_0:CH_9]}) begin
                a = UA_DIGIT;
            end else begin
                case (ch)
                    CH_J:    a = num_two ? UA_CLEAR : UA_ESC_OTHER;
                    CH_H:    a = UA_HOME;
                    CH_K:    a = UA_ERASE;
                    default: a = UA_ESC_OTHER;
                endcase
            end
        end else begin
            case (ch)
                CH_ESC:  a = UA_ESC;
                CH_LF:   a = UA_LF;
                CH_CR:   a = UA_CR;
                CH_BS:   a = UA_BS;
                CH_TAB:  a = UA_TAB;
                default: a = (ch < CH_FIRST) ? UA_CTRL : UA_PRINT;
            endcase
        end
        return a;
    endfunction

endpackage

// ===== rtl/core/tcce_seq.sv =====
// ----------------------------------------------------------------------------
// Text console character engine sequencer
// Step counter over the control store, with dispatch and conditional jumps.
// ----------------------------------------------------------------------------
`include "text_console_char_engine_assert.svh"

module tcce_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [7:0]         i_char_byte,
    input  tcce_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output logic               o_start,
    output tcce_pkg::t_dp_ctl  o_ctl
);
    import tcce_pkg::*;

    logic       r_busy;
    logic       n_busy;
    logic [3:0] r_pc;
    logic [3:0] n_pc;
    t_uword     word;
    logic       fire;
    logic       take;

    assign word       = ucode_word(r_pc);
    assign fire       = r_busy && ((word.emit == EM_NONE) || i_stat.out_free);
    assign o_in_ready = !r_busy;
    assign o_start    = i_in_valid && !r_busy;
    assign o_ctl.word = word;
    assign o_ctl.fire = fire;

    always_comb begin
        case (word.jc)
            JC_SCR:  take = i_stat.scr;
            JC_MORE: take = i_stat.more;
            default: take = 1'b0;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (o_start) begin
            n_busy = 1'b1;
            n_pc   = dispatch(i_char_byte, i_stat.phase, i_stat.num_two);
        end else if (fire) begin
            if (take) begin
                n_pc = word.target;
            end else if (word.fin) begin
                n_busy = 1'b0;
            end else begin
                n_pc = r_pc + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= UA_CTRL;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    `TCCE_ASSERT_NEXT(a_stall_holds, r_busy && !fire, r_busy && $stable(r_pc))
    `TCCE_ASSERT_NEXT(a_last_ends_item,
                      fire && (word.emit != EM_NONE) && (word.last == LS_YES), !r_busy)

endmodule

// ===== rtl/core/tcce_datapath.sv =====
// ----------------------------------------------------------------------------
// Text console character engine datapath
// Cursor and escape state, tab span, and the registered result stage.
// ----------------------------------------------------------------------------
`include "text_console_char_engine_assert.svh"

module tcce_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [7:0]                   i_char_byte,
    input  logic [7:0]                   i_ncols,
    input  logic [6:0]                   i_nrows,
    input  tcce_pkg::t_dp_ctl            i_ctl,
    input  logic                         i_out_ready,
    output tcce_pkg::t_dp_stat           o_stat,
    output logic                         o_out_valid,
    output logic [2:0]                   o_op_kind,
    output logic [tcce_pkg::COL_W-1:0]   o_target_col,
    output logic [tcce_pkg::ROW_W-1:0]   o_target_row,
    output logic [7:0]                   o_glyph_code,
    output logic [tcce_pkg::COL_W-1:0]   o_cursor_col_out,
    output logic [tcce_pkg::ROW_W-1:0]   o_cursor_row_out,
    output logic                         o_last_of_run
);
    import tcce_pkg::*;

    logic [COL_W-1:0] r_col, n_col, r_wcol, clp_col;
    logic [ROW_W-1:0] r_row, n_row, r_wrow, clp_row, lf_row;
    logic [7:0]       r_end, n_end;
    logic             r_scr, n_scr, lf_scr;
    logic [7:0]       r_byte;
    logic [1:0]       r_phase;
    logic [NUM_W-1:0] r_num;
    logic [19:0]      num_next;
    logic [7:0]       ncols_m1, adv, tab_e;
    logic [6:0]       nrows_m1, row_inc;
    logic             more;
    logic             emit_fire;

    logic             r_ov;
    logic [2:0]       r_kind, n_kind;
    logic [COL_W-1:0] r_tcol, n_tcol, r_ccol;
    logic [ROW_W-1:0] r_trow, n_trow, r_crow;
    logic [7:0]       r_glyph, n_glyph;
    logic             r_last, n_last;

    assign ncols_m1 = i_ncols - 8'd1;
    assign nrows_m1 = i_nrows - 7'd1;
    assign clp_col  = ({1'b0, r_col} >= i_ncols) ? ncols_m1[COL_W-1:0] : r_col;
    assign clp_row  = ({1'b0, r_row} >= i_nrows) ? nrows_m1[ROW_W-1:0] : r_row;

    assign row_inc  = {1'b0, r_wrow} + 7'd1;
    assign lf_scr   = (row_inc >= i_nrows);
    assign lf_row   = lf_scr ? nrows_m1[ROW_W-1:0] : row_inc[ROW_W-1:0];
    assign adv      = {1'b0, r_wcol} + 8'd1;
    assign tab_e    = (({1'b0, r_wcol} / TAB_WIDTH) + 8'd1) * TAB_WIDTH;
    assign more     = (adv != r_end);
    assign num_next = ({4'd0, r_num} << 3) + ({4'd0, r_num} << 1)
                    + {16'd0, r_byte[3:0] - CH_0[3:0]};

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_scr = r_scr;
        n_end = r_end;
        if (i_ctl.fire) begin
            case (i_ctl.word.cur)
                CUR_HOME: begin
                    n_col = '0;
                    n_row = '0;
                end
                CUR_CR: n_col = '0;
                CUR_BS: n_col = (r_wcol != '0) ? r_wcol - 7'd1 : '0;
                CUR_ADV: begin
                    if (adv >= i_ncols) begin
                        n_col = '0;
                        n_row = lf_row;
                        n_scr = lf_scr;
                    end else begin
                        n_col = adv[COL_W-1:0];
                    end
                end
                CUR_TAB: begin
                    if (tab_e >= i_ncols) begin
                        n_end = i_ncols;
                        n_col = '0;
                        n_row = lf_row;
                        n_scr = lf_scr;
                    end else begin
                        n_end = tab_e;
                        n_col = tab_e[COL_W-1:0];
                    end
                end
                CUR_LF: begin
                    n_col = '0;
                    n_row = lf_row;
                    n_scr = lf_scr;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_kind  = OP_CURSOR;
        n_tcol  = '0;
        n_trow  = '0;
        n_glyph = '0;
        case (i_ctl.word.emit)
            EM_WRITE_BYTE: begin
                n_kind  = OP_WRITE;
                n_tcol  = r_wcol;
                n_trow  = r_wrow;
                n_glyph = r_byte;
            end
            EM_WRITE_SPACE: begin
                n_kind  = OP_WRITE;
                n_tcol  = r_wcol;
                n_trow  = r_wrow;
                n_glyph = CH_SPACE;
            end
            EM_ERASE: begin
                n_kind  = OP_ERASE;
                n_tcol  = r_wcol;
                n_trow  = r_wrow;
                n_glyph = CH_SPACE;
            end
            EM_SCROLL:     n_kind = OP_SCROLL;
            EM_CLEAR:      n_kind = OP_CLEAR;
            EM_SCR_OR_CUR: n_kind = n_scr ? OP_SCROLL : OP_CURSOR;
            default:       n_kind = OP_CURSOR;
        endcase
        case (i_ctl.word.last)
            LS_NOSCR: n_last = !n_scr;
            LS_TAB:   n_last = !more && !n_scr;
            default:  n_last = 1'b1;
        endcase
    end

    assign emit_fire = i_ctl.fire && (i_ctl.word.emit != EM_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= PH_IDLE;
            r_num   <= '0;
            r_scr   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_start) begin
                r_col <= clp_col;
                r_row <= clp_row;
                r_scr <= 1'b0;
            end else begin
                r_col <= n_col;
                r_row <= n_row;
                r_scr <= n_scr;
            end
            if (i_ctl.fire) begin
                case (i_ctl.word.esc)
                    ES_IDLE: r_phase <= PH_IDLE;
                    ES_ESC:  r_phase <= PH_ESC;
                    ES_CSI: begin
                        r_phase <= PH_CSI;
                        r_num   <= '0;
                    end
                    ES_DIGIT: r_num <= (num_next > {4'd0, NUM_MAX}) ? NUM_MAX
                                                                     : num_next[NUM_W-1:0];
                    default: ;
                endcase
            end
            if (emit_fire) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_wcol <= clp_col;
            r_wrow <= clp_row;
            r_byte <= i_char_byte;
        end else if (i_ctl.fire && i_ctl.word.wcinc) begin
            r_wcol <= adv[COL_W-1:0];
        end
        r_end <= n_end;
        if (emit_fire) begin
            r_kind  <= n_kind;
            r_tcol  <= n_tcol;
            r_trow  <= n_trow;
            r_glyph <= n_glyph;
            r_ccol  <= n_col;
            r_crow  <= n_row;
            r_last  <= n_last;
        end
    end

    assign o_stat.out_free = !r_ov || i_out_ready;
    assign o_stat.scr      = n_scr;
    assign o_stat.more     = more;
    assign o_stat.phase    = r_phase;
    assign o_stat.num_two  = (r_num == NUM_CLEAR_ALL);

    assign o_out_valid      = r_ov;
    assign o_op_kind        = r_kind;
    assign o_target_col     = r_tcol;
    assign o_target_row     = r_trow;
    assign o_glyph_code     = r_glyph;
    assign o_cursor_col_out = r_ccol;
    assign o_cursor_row_out = r_crow;
    assign o_last_of_run    = r_last;

    `TCCE_ASSERT_NOW(a_tab_in_span, i_ctl.fire && i_ctl.word.wcinc, {1'b0, r_wcol} < r_end)

endmodule

// ===== rtl/core/text_console_char_engine.sv =====
// ----------------------------------------------------------------------------
// Text console character engine
// Turns console bytes into screen commands and cursor updates.
// ----------------------------------------------------------------------------
// Input items are bytes on i_in_valid / o_in_ready with i_char_byte. Each byte
// yields one or more result items on o_out_valid / i_out_ready; the final one
// has o_last_of_run set, and every item carries the cursor after the byte.
// A microcoded sequencer steps through a short routine per byte, one control
// word per cycle; each word may drive one item into the output register.
// The first item comes from the routine's first word, except for a tab, whose
// first word only sets the tab span and emits nothing. A printable byte that
// scrolls emits its write and then a scroll, and a tab writes spaces up to
// the next tab stop or the line end, then a scroll if the cursor wrapped past
// the bottom row. A new byte is taken once the last word of the previous
// routine has issued. When the receiver stalls, a word that emits waits
// until the output register is free, and the engine holds its step.
// Reset homes the cursor, clears the escape parser and sets the screen to
// 80 columns by 30 rows. Configuration writes through i_cfg_we take effect
// at once; the user must make them while the engine is idle (not enforced).
// ----------------------------------------------------------------------------
module text_console_char_engine (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [7:0]                   i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [7:0]                   i_char_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [2:0]                   o_op_kind,
    output logic [tcce_pkg::COL_W-1:0]   o_target_col,
    output logic [tcce_pkg::ROW_W-1:0]   o_target_row,
    output logic [7:0]                   o_glyph_code,
    output logic [tcce_pkg::COL_W-1:0]   o_cursor_col_out,
    output logic [tcce_pkg::ROW_W-1:0]   o_cursor_row_out,
    output logic                         o_last_of_run
);
    import tcce_pkg::*;

    logic [7:0] r_cols;
    logic [6:0] r_rows;
    logic [7:0] ncols;
    logic [6:0] nrows;
    logic       start;
    t_dp_ctl    ctl;
    t_dp_stat   stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= RESET_COLUMNS;
            r_rows <= RESET_ROWS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCREEN_COLUMNS: r_cols <= i_cfg_wdata;
                CFG_SCREEN_ROWS:    r_rows <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    assign ncols = (r_cols == 8'd0) ? 8'd1 : ((r_cols > MAX_COLUMNS) ? MAX_COLUMNS : r_cols);
    assign nrows = (r_rows == 7'd0) ? 7'd1 : ((r_rows > MAX_LINES) ? MAX_LINES : r_rows);

    tcce_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_char_byte (i_char_byte),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_start     (start),
        .o_ctl       (ctl)
    );

    tcce_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_char_byte      (i_char_byte),
        .i_ncols          (ncols),
        .i_nrows          (nrows),
        .i_ctl            (ctl),
        .i_out_ready      (i_out_ready),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .o_op_kind        (o_op_kind),
        .o_target_col     (o_target_col),
        .o_target_row     (o_target_row),
        .o_glyph_code     (o_glyph_code),
        .o_cursor_col_out (o_cursor_col_out),
        .o_cursor_row_out (o_cursor_row_out),
        .o_last_of_run    (o_last_of_run)
    );

endmodule
